[rtl/dfa_pkg.sv]
// dfa_pkg: shared constants, codes and types of the automaton word acceptor
`default_nettype none

package dfa_pkg;

  localparam int NUM_STATES_DEF      = 16;
  localparam int MAX_TRANSITIONS_DEF = 32;
  localparam int SYM_W               = 8;
  localparam int CFG_IDX_W           = 2;
  localparam logic [SYM_W-1:0] MARKER_SYMBOL = 8'h2A;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_START  = 2'd1,
    OP_SYMBOL = 2'd2,
    OP_END    = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INITIAL = 2'd0,
    CFG_FINAL   = 2'd1,
    CFG_COUNT   = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    V_NONE     = 3'd0,
    V_ACCEPT   = 3'd1,
    V_NOTRANS  = 3'd2,
    V_NOTFINAL = 3'd3,
    V_MARKER   = 3'd4
  } verdict_t;

  typedef enum logic [1:0] {
    F_LIVE    = 2'd0,
    F_NOTRANS = 2'd1,
    F_MARKER  = 2'd2
  } fault_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_SEARCH = 2'b10
  } ctrl_state_t;

  typedef struct packed {
    logic searching;
    logic pend_valid;
  } dfa_stat_t;

  function automatic int idx_bits(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

`default_nettype wire

[rtl/dfa_tbl.sv]
// dfa_tbl: transition table memory, one write port and one registered read port
`default_nettype none

module dfa_tbl import dfa_pkg::*; #(
  parameter int DEPTH   = MAX_TRANSITIONS_DEF,
  parameter int ENTRY_W = 2 * idx_bits(NUM_STATES_DEF) + SYM_W,
  localparam int IDX_W  = idx_bits(DEPTH)
) (
  input  wire logic               clk,
  input  wire logic               we,
  input  wire logic [IDX_W-1:0]   waddr,
  input  wire logic [ENTRY_W-1:0] wdata,
  input  wire logic [IDX_W-1:0]   raddr,
  output logic      [ENTRY_W-1:0] rdata
);

  logic [ENTRY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/dfa_ctrl.sv]
// dfa_ctrl: configuration, word state, table search sequencer and result staging
`default_nettype none

module dfa_ctrl import dfa_pkg::*; #(
  parameter int NUM_STATES      = NUM_STATES_DEF,
  parameter int MAX_TRANSITIONS = MAX_TRANSITIONS_DEF,
  localparam int STATE_W = idx_bits(NUM_STATES),
  localparam int IDX_W   = idx_bits(MAX_TRANSITIONS),
  localparam int CNT_W   = $clog2(MAX_TRANSITIONS + 1),
  localparam int CFG_W   = (NUM_STATES > CNT_W) ? NUM_STATES : CNT_W,
  localparam int ENTRY_W = 2 * STATE_W + SYM_W
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [1:0]           op,
  input  wire logic [IDX_W-1:0]     entry_index,
  input  wire logic [STATE_W-1:0]   from_state,
  input  wire logic [STATE_W-1:0]   to_state,
  input  wire logic [SYM_W-1:0]     symbol,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [2:0]                verdict,
  output logic [STATE_W-1:0]        present_state,
  output logic                      tbl_we,
  output logic [IDX_W-1:0]          tbl_waddr,
  output logic [ENTRY_W-1:0]        tbl_wdata,
  output logic [IDX_W-1:0]          tbl_raddr,
  input  wire logic [ENTRY_W-1:0]   tbl_rdata,
  output dfa_stat_t                 stat
);

  logic [STATE_W-1:0]    initial_state;
  logic [NUM_STATES-1:0] final_state_mask;
  logic [CNT_W-1:0]      transition_count;

  ctrl_state_t        state, state_next;
  logic [STATE_W-1:0] cur, cur_next;
  fault_t             fault, fault_next;
  logic [CNT_W-1:0]   k, k_next;
  logic [CNT_W-1:0]   lim, lim_next;
  logic [SYM_W-1:0]   sym_q, sym_q_next;

  logic               pend_valid;
  verdict_t           pend_verdict;
  logic [STATE_W-1:0] pend_state;

  logic               accept;
  logic               res_en;
  verdict_t           res_verdict;
  logic [STATE_W-1:0] res_state;
  logic [CNT_W-1:0]   lim_now;
  logic [CNT_W-1:0]   k_inc;
  logic               is_final;
  verdict_t           fault_verdict;
  logic [STATE_W-1:0] rd_from;
  logic [STATE_W-1:0] rd_to;
  logic [SYM_W-1:0]   rd_sym;
  logic               out_free;

  assign in_stall = (state != ST_IDLE) || pend_valid;
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign lim_now  = (transition_count > CNT_W'(MAX_TRANSITIONS)) ?
                    CNT_W'(MAX_TRANSITIONS) : transition_count;
  assign k_inc    = k + CNT_W'(1);
  assign is_final = ({1'b0, cur} < (STATE_W + 1)'(NUM_STATES)) && final_state_mask[cur];
  assign fault_verdict = (fault == F_MARKER) ? V_MARKER : V_NOTRANS;

  assign rd_from = tbl_rdata[ENTRY_W-1 -: STATE_W];
  assign rd_to   = tbl_rdata[SYM_W +: STATE_W];
  assign rd_sym  = tbl_rdata[SYM_W-1:0];

  assign tbl_waddr = entry_index;
  assign tbl_wdata = {from_state, to_state, symbol};

  assign stat.searching  = (state == ST_SEARCH);
  assign stat.pend_valid = pend_valid;

  always_comb begin
    state_next  = state;
    cur_next    = cur;
    fault_next  = fault;
    k_next      = k;
    lim_next    = lim;
    sym_q_next  = sym_q;
    res_en      = 1'b0;
    res_verdict = V_NONE;
    res_state   = cur;
    tbl_we      = 1'b0;
    tbl_raddr   = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (op_t'(op))
            OP_LOAD: begin
              tbl_we = ({1'b0, entry_index} < (IDX_W + 1)'(MAX_TRANSITIONS));
              res_en = 1'b1;
            end
            OP_START: begin
              cur_next   = initial_state;
              fault_next = F_LIVE;
              res_en     = 1'b1;
              res_state  = initial_state;
            end
            OP_SYMBOL: begin
              priority if (fault != F_LIVE) begin
                res_en      = 1'b1;
                res_verdict = fault_verdict;
              end else if (symbol == MARKER_SYMBOL) begin
                fault_next  = F_MARKER;
                res_en      = 1'b1;
                res_verdict = V_MARKER;
              end else if (lim_now == '0) begin
                fault_next  = F_NOTRANS;
                res_en      = 1'b1;
                res_verdict = V_NOTRANS;
              end else begin
                // entry 0 is read now, its data arrives in the first search cycle
                state_next = ST_SEARCH;
                k_next     = '0;
                lim_next   = lim_now;
                sym_q_next = symbol;
              end
            end
            OP_END: begin
              res_en = 1'b1;
              priority if (fault != F_LIVE) begin
                res_verdict = fault_verdict;
              end else if (is_final) begin
                res_verdict = V_ACCEPT;
              end else begin
                res_verdict = V_NOTFINAL;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SEARCH: begin
        tbl_raddr = k_inc[IDX_W-1:0];
        priority if ((rd_from == cur) && (rd_sym == sym_q)) begin
          cur_next   = rd_to;
          state_next = ST_IDLE;
          res_en     = 1'b1;
          res_state  = rd_to;
        end else if (k_inc == lim) begin
          fault_next  = F_NOTRANS;
          state_next  = ST_IDLE;
          res_en      = 1'b1;
          res_verdict = V_NOTRANS;
        end else begin
          k_next = k_inc;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      initial_state    <= '0;
      final_state_mask <= '0;
      transition_count <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_INITIAL: initial_state    <= cfg_data[STATE_W-1:0];
        CFG_FINAL:   final_state_mask <= cfg_data[NUM_STATES-1:0];
        CFG_COUNT:   transition_count <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cur   <= '0;
      fault <= F_LIVE;
    end else begin
      state <= state_next;
      cur   <= cur_next;
      fault <= fault_next;
    end
  end

  always_ff @(posedge clk) begin
    k     <= k_next;
    lim   <= lim_next;
    sym_q <= sym_q_next;
  end

  // result staging: output register plus one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      priority if (pend_valid && out_free) begin
        out_valid  <= 1'b1;
        pend_valid <= 1'b0;
      end else if (res_en) begin
        if (out_free) begin
          out_valid <= 1'b1;
        end else begin
          pend_valid <= 1'b1;
        end
      end else if (out_free) begin
        out_valid <= 1'b0;
      end else begin
      end
    end
  end

  always_ff @(posedge clk) begin
    priority if (pend_valid && out_free) begin
      verdict       <= pend_verdict;
      present_state <= pend_state;
    end else if (res_en) begin
      if (out_free) begin
        verdict       <= res_verdict;
        present_state <= res_state;
      end else begin
        pend_verdict <= res_verdict;
        pend_state   <= res_state;
      end
    end else begin
    end
  end

endmodule

`default_nettype wire

[rtl/dfa_word_acceptor_top.sv]
// dfa_word_acceptor_top: top level of the automaton word acceptor
// Load, start and end items give their result without a table search, and so
// does a symbol item on a dead word, on the marker symbol or with no table
// entries in use. Any other symbol item on a live word searches the
// transition table in order, one entry per cycle through the table's single
// registered read port, and ends at the first matching entry or, when none
// matches, after the entries in use (transition_count, capped at
// MAX_TRANSITIONS). A result waiting on the output does not block the next
// item; a second finished result does.
`default_nettype none

module dfa_word_acceptor_top import dfa_pkg::*; #(
  parameter int NUM_STATES      = NUM_STATES_DEF,
  parameter int MAX_TRANSITIONS = MAX_TRANSITIONS_DEF,
  localparam int STATE_W = idx_bits(NUM_STATES),
  localparam int IDX_W   = idx_bits(MAX_TRANSITIONS),
  localparam int CNT_W   = $clog2(MAX_TRANSITIONS + 1),
  localparam int CFG_W   = (NUM_STATES > CNT_W) ? NUM_STATES : CNT_W
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [1:0]           op,
  input  wire logic [IDX_W-1:0]     entry_index,
  input  wire logic [STATE_W-1:0]   from_state,
  input  wire logic [STATE_W-1:0]   to_state,
  input  wire logic [SYM_W-1:0]     symbol,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [2:0]                verdict,
  output logic [STATE_W-1:0]        present_state
);

  localparam int ENTRY_W = 2 * STATE_W + SYM_W;

  logic               tbl_we;
  logic [IDX_W-1:0]   tbl_waddr;
  logic [ENTRY_W-1:0] tbl_wdata;
  logic [IDX_W-1:0]   tbl_raddr;
  logic [ENTRY_W-1:0] tbl_rdata;
  dfa_stat_t          stat;

  dfa_tbl #(
    .DEPTH   (MAX_TRANSITIONS),
    .ENTRY_W (ENTRY_W)
  ) u_tbl (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  dfa_ctrl #(
    .NUM_STATES      (NUM_STATES),
    .MAX_TRANSITIONS (MAX_TRANSITIONS)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .op            (op),
    .entry_index   (entry_index),
    .from_state    (from_state),
    .to_state      (to_state),
    .symbol        (symbol),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .verdict       (verdict),
    .present_state (present_state),
    .tbl_we        (tbl_we),
    .tbl_waddr     (tbl_waddr),
    .tbl_wdata     (tbl_wdata),
    .tbl_raddr     (tbl_raddr),
    .tbl_rdata     (tbl_rdata),
    .stat          (stat)
  );

  a_search_blocks_input: assert property (@(posedge clk) disable iff (rst)
    stat.searching |-> in_stall)
    else $error("item taken during a table search");

  a_skid_only_when_full: assert property (@(posedge clk) disable iff (rst)
    stat.pend_valid |-> out_valid)
    else $error("skid entry holds a result while the output is empty");

  a_short_item_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && (op != OP_SYMBOL) && !out_valid) |=> out_valid)
    else $error("single-cycle item gave no result");

  a_table_quiet_in_search: assert property (@(posedge clk) disable iff (rst)
    stat.searching |-> !tbl_we)
    else $error("table written during a search");

endmodule

`default_nettype wire
